### rtl/core/bpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bar peak meter package
// Shared types, register codes and constants of the bar and peak ballistics.
// ----------------------------------------------------------------------------
package bpm_pkg;

    localparam int BANDS_DEF   = 24;
    localparam int BAND_W      = 5;
    localparam int BAND_CMP_W  = 7;    // holds any band count up to 127
    localparam int LEVEL_W     = 16;
    localparam int VIS_W       = 9;
    localparam int HEIGHT_W    = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [LEVEL_W-1:0] MAX16    = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] SNAP_Q88 = 16'd13;     // 0.05 in Q8.8
    localparam logic [VIS_W-1:0]   VIS_ONE  = 9'd256;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_ATTACK = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DECAY  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL  = 2'd3;

    localparam logic [CFG_DATA_W-1:0] RST_ATTACK = 16'd19661;
    localparam logic [CFG_DATA_W-1:0] RST_DECAY  = 16'd55705;
    localparam logic [CFG_DATA_W-1:0] RST_HOLD   = 16'd25;
    localparam logic [CFG_DATA_W-1:0] RST_ACCEL  = 16'd26;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] attack_coeff;
        logic [CFG_DATA_W-1:0] decay_coeff;
        logic [CFG_DATA_W-1:0] hold_ticks;
        logic [CFG_DATA_W-1:0] peak_accel;
    } t_cfg;

    // One classified update as it travels from front to back
    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic               out_of_range;
        logic               fresh;
        logic [LEVEL_W-1:0] level;
        logic [VIS_W-1:0]   vis;          // already clamped to one
    } t_item;

endpackage

### rtl/core/bar_peak_meter_ballistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bar peak meter ballistics
// Per-band VU bar smoothing with attack and decay, peak hold and peak fall.
// ----------------------------------------------------------------------------
// Path from input transfer to result for an in-range band: front register,
// queue, state read, target, two blend steps, peak update, output register;
// out-of-range bands skip the arithmetic. The back-end sequencer that does the
// read-modify-write of the per-band state memory takes the next band update
// only after the last one reaches the output register, which stalls can delay.
// Reset: synchronous, active low; restores the register defaults and marks
// every band's state as zero through per-band valid bits, with no sweep.
// ----------------------------------------------------------------------------
module bar_peak_meter_ballistics #(
    parameter int BANDS = bpm_pkg::BANDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [bpm_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [bpm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // band update channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [bpm_pkg::BAND_W-1:0]        i_in_band,
    input  logic                              i_has_new_level,
    input  logic [bpm_pkg::LEVEL_W-1:0]       i_new_level,
    input  logic [bpm_pkg::VIS_W-1:0]         i_visibility,
    // height channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [bpm_pkg::BAND_W-1:0]        o_out_band,
    output logic [bpm_pkg::HEIGHT_W-1:0]      o_bar_height,
    output logic [bpm_pkg::HEIGHT_W-1:0]      o_peak_height
);

    bpm_pkg::t_cfg  r_cfg;
    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;
    bpm_pkg::t_item w_front_item;
    bpm_pkg::t_item w_head_item;

    // Configuration registers; the user writes them only while idle (the block
    // does not enforce this), so the back end reads them live, unshadowed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_coeff <= bpm_pkg::RST_ATTACK;
            r_cfg.decay_coeff  <= bpm_pkg::RST_DECAY;
            r_cfg.hold_ticks   <= bpm_pkg::RST_HOLD;
            r_cfg.peak_accel   <= bpm_pkg::RST_ACCEL;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                bpm_pkg::CFG_ATTACK: r_cfg.attack_coeff <= i_cfg_wdata;
                bpm_pkg::CFG_DECAY:  r_cfg.decay_coeff  <= i_cfg_wdata;
                bpm_pkg::CFG_HOLD:   r_cfg.hold_ticks   <= i_cfg_wdata;
                bpm_pkg::CFG_ACCEL:  r_cfg.peak_accel   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front end: take each transfer, flag bands past the end, clamp visibility
    bpm_front #(
        .BANDS (BANDS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_band       (i_in_band),
        .i_has_new_level (i_has_new_level),
        .i_new_level     (i_new_level),
        .i_visibility    (i_visibility),
        .o_push          (w_push),
        .o_item          (w_front_item),
        .i_full          (w_full)
    );

    // Queue: lets the front keep taking transfers while the back is busy
    bpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_empty (w_empty)
    );

    // Back end: read band state, advance bar and peak, write back, scale
    bpm_back #(
        .BANDS (BANDS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (w_empty),
        .i_item        (w_head_item),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_band    (o_out_band),
        .o_bar_height  (o_bar_height),
        .o_peak_height (o_peak_height)
    );

endmodule

### rtl/core/bpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bar peak meter front end
// Accepts band updates, flags out-of-range bands and clamps visibility.
// ----------------------------------------------------------------------------
module bpm_front #(
    parameter int BANDS = bpm_pkg::BANDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bpm_pkg::BAND_W-1:0]      i_in_band,
    input  logic                            i_has_new_level,
    input  logic [bpm_pkg::LEVEL_W-1:0]     i_new_level,
    input  logic [bpm_pkg::VIS_W-1:0]       i_visibility,
    output logic                            o_push,
    output bpm_pkg::t_item                  o_item,
    input  logic                            i_full
);

    logic           r_vld;
    bpm_pkg::t_item r_item;
    bpm_pkg::t_item n_item;
    logic           w_take;

    assign o_ready = !r_vld || !i_full;
    assign w_take  = i_valid && o_ready;
    assign o_push  = r_vld;
    assign o_item  = r_item;

    always_comb begin
        n_item.band         = i_in_band;
        n_item.out_of_range = bpm_pkg::BAND_CMP_W'(i_in_band)
                              >= bpm_pkg::BAND_CMP_W'(BANDS);
        n_item.fresh        = i_has_new_level;
        n_item.level        = i_new_level;
        n_item.vis          = (i_visibility > bpm_pkg::VIS_ONE) ? bpm_pkg::VIS_ONE
                                                                : i_visibility;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (r_vld && !i_full) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

endmodule

### rtl/core/bpm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bar peak meter queue
// Short FIFO of classified updates between the front and back ends.
// ----------------------------------------------------------------------------
module bpm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bpm_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output bpm_pkg::t_item o_item,
    output logic           o_empty
);

    bpm_pkg::t_item                r_slot [bpm_pkg::QUEUE_DEPTH];
    logic [bpm_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [bpm_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [bpm_pkg::QPTR_W:0]      r_count;
    logic                          w_wr;
    logic                          w_rd;

    assign o_full  = r_count == (bpm_pkg::QPTR_W + 1)'(bpm_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_slot[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/core/bpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bar peak meter back end
// Per-band read-modify-write of bar and peak state, and display heights.
// ----------------------------------------------------------------------------
module bpm_back #(
    parameter int BANDS = bpm_pkg::BANDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpm_pkg::t_cfg                 i_cfg,
    input  logic                          i_empty,
    input  bpm_pkg::t_item                i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bpm_pkg::BAND_W-1:0]    o_out_band,
    output logic [bpm_pkg::HEIGHT_W-1:0]  o_bar_height,
    output logic [bpm_pkg::HEIGHT_W-1:0]  o_peak_height
);

    localparam int IDX_W = (BANDS > 1) ? $clog2(BANDS) : 1;

    typedef struct packed {
        logic [bpm_pkg::LEVEL_W-1:0] bar;
        logic [bpm_pkg::LEVEL_W-1:0] peak;
        logic [bpm_pkg::LEVEL_W-1:0] speed;
        logic [bpm_pkg::LEVEL_W-1:0] held;
        logic                        falling;
    } t_band_state;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_TGT  = 6'b000010,
        ST_MIX1 = 6'b000100,
        ST_MIX2 = 6'b001000,
        ST_PEAK = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    function automatic logic [bpm_pkg::HEIGHT_W-1:0] scale_height(
        input logic [bpm_pkg::LEVEL_W-1:0] lvl,
        input logic [bpm_pkg::VIS_W-1:0]   vis
    );
        logic [24:0] p;
        p = lvl * vis + 25'd32768;
        scale_height = p[24] ? 8'hFF : p[23:16];
    endfunction

    t_band_state                  r_mem [BANDS];
    t_band_state                  r_rd;
    logic                         r_rd_vld;
    logic [BANDS-1:0]             r_bvld;
    t_state                       r_state;
    bpm_pkg::t_item               r_item;
    logic [bpm_pkg::LEVEL_W-1:0]  r_tgt;
    logic [bpm_pkg::LEVEL_W-1:0]  r_coef;
    logic [32:0]                  r_prod;
    logic [bpm_pkg::LEVEL_W-1:0]  r_lvl;
    logic [bpm_pkg::LEVEL_W-1:0]  r_pk;
    logic [bpm_pkg::HEIGHT_W-1:0] r_bh;
    logic                         r_out_vld;
    logic [bpm_pkg::BAND_W-1:0]   r_out_band;
    logic [bpm_pkg::HEIGHT_W-1:0] r_out_bh;
    logic [bpm_pkg::HEIGHT_W-1:0] r_out_ph;

    t_band_state                  w_cur;
    t_band_state                  n_st;
    logic [IDX_W-1:0]             w_rd_idx;
    logic [IDX_W-1:0]             w_wr_idx;
    logic                         w_start;
    logic                         w_wr;
    logic                         w_out_free;
    logic                         w_load;
    logic [31:0]                  w_idle;
    logic [bpm_pkg::LEVEL_W-1:0]  w_c;
    logic [16:0]                  w_onec;
    logic [32:0]                  w_mul1;
    logic [31:0]                  w_mul2;
    logic [33:0]                  w_mix;
    logic [bpm_pkg::LEVEL_W-1:0]  w_mix_sat;
    logic [bpm_pkg::HEIGHT_W-1:0] w_ph;

    assign w_cur      = r_rd_vld ? r_rd : '0;
    assign w_rd_idx   = IDX_W'(i_item.band);
    assign w_wr_idx   = IDX_W'(r_item.band);
    assign w_start    = (r_state == ST_IDLE) && !i_empty;
    assign w_wr       = r_state == ST_PEAK;
    assign w_out_free = !r_out_vld || i_ready;
    assign w_load     = (r_state == ST_OUT) && w_out_free;
    assign o_pop      = w_start;

    assign o_valid       = r_out_vld;
    assign o_out_band    = r_out_band;
    assign o_bar_height  = r_out_bh;
    assign o_peak_height = r_out_ph;

    // Idle target: decay the bar toward zero
    assign w_idle = w_cur.bar * i_cfg.decay_coeff;

    // Blend target and old bar; old-bar weight picks attack or decay
    assign w_c    = (r_tgt > w_cur.bar) ? i_cfg.attack_coeff : i_cfg.decay_coeff;
    assign w_onec = 17'h10000 - {1'b0, w_c};
    assign w_mul1 = r_tgt * w_onec;
    assign w_mul2 = w_cur.bar * r_coef;
    assign w_mix  = {1'b0, r_prod} + {2'b00, w_mul2} + 34'd32768;
    assign w_mix_sat = (w_mix[33:32] != 2'b00) ? bpm_pkg::MAX16 : w_mix[31:16];

    // Peak capture, hold and fall
    always_comb begin
        logic [16:0] v_sp;
        n_st     = w_cur;
        n_st.bar = r_lvl;
        v_sp     = '0;
        if (r_lvl >= w_cur.peak) begin
            n_st.peak    = r_lvl;
            n_st.held    = '0;
            n_st.falling = 1'b0;
            n_st.speed   = '0;
        end else begin
            if (!w_cur.falling) begin
                if (w_cur.held != bpm_pkg::MAX16) begin
                    n_st.held = w_cur.held + 16'd1;
                end
                if (n_st.held >= i_cfg.hold_ticks) begin
                    n_st.falling = 1'b1;
                    n_st.speed   = '0;
                end
            end
            v_sp = {1'b0, n_st.speed} + {1'b0, i_cfg.peak_accel};
            if (n_st.falling) begin
                n_st.speed = v_sp[16] ? bpm_pkg::MAX16 : v_sp[15:0];
                if (n_st.speed >= w_cur.peak || (w_cur.peak - n_st.speed) <= r_lvl) begin
                    n_st.peak    = r_lvl;
                    n_st.falling = 1'b0;
                    n_st.speed   = '0;
                end else begin
                    n_st.peak = w_cur.peak - n_st.speed;
                end
            end
        end
    end

    // Drop a stray peak of one step over an empty bar
    always_comb begin
        w_ph = scale_height(r_pk, r_item.vis);
        if (r_bh == '0 && w_ph <= 8'd1) begin
            w_ph = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bvld    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_start) begin
                r_rd_vld <= r_bvld[w_rd_idx];
            end
            if (w_wr) begin
                r_bvld[w_wr_idx] <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_start) begin
                        r_state <= i_item.out_of_range ? ST_OUT : ST_TGT;
                    end
                end
                ST_TGT:  r_state <= ST_MIX1;
                ST_MIX1: r_state <= ST_MIX2;
                ST_MIX2: r_state <= ST_PEAK;
                ST_PEAK: r_state <= ST_OUT;
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_wr_idx] <= n_st;
        end
        if (w_start) begin
            r_rd <= r_mem[w_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_item <= i_item;
        end
        if (r_state == ST_TGT) begin
            r_tgt <= r_item.fresh ? r_item.level : w_idle[31:16] + {15'd0, w_idle[15]};
        end
        if (r_state == ST_MIX1) begin
            r_coef <= w_c;
            r_prod <= w_mul1;
        end
        if (r_state == ST_MIX2) begin
            r_lvl <= (w_mix_sat < bpm_pkg::SNAP_Q88) ? '0 : w_mix_sat;
        end
        if (r_state == ST_PEAK) begin
            r_pk <= n_st.peak;
            r_bh <= scale_height(r_lvl, r_item.vis);
        end
        if (w_load) begin
            r_out_band <= r_item.band;
            r_out_bh   <= r_item.out_of_range ? '0 : r_bh;
            r_out_ph   <= r_item.out_of_range ? '0 : w_ph;
        end
    end

endmodule

### tb/tb_bar_peak_meter_ballistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bar peak meter ballistics testbench
// Drives per-band updates through the valid/ready input channel, predicts the
// smoothed bar, the peak hold and the peak fall of every band, and checks each
// transferred height result against the oldest predicted result. Runs a short
// directed sequence, then random phases under several register settings, with
// random idle bursts on both channels, none in every third phase or the last.
// ----------------------------------------------------------------------------
module tb_bar_peak_meter_ballistics;

    import bpm_pkg::*;

    localparam int N_BANDS      = BANDS_DEF;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 12;       // block latency plus margin
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 150;

    // ------------------------------------------------------------------------
    // Per-band meter tracker: holds its own copy of the registers and of the
    // band state, computes the heights of every update, and checks results.
    // ------------------------------------------------------------------------
    class meter_tracker;
        typedef struct packed {
            logic [BAND_W-1:0]   band;
            logic [HEIGHT_W-1:0] bar;
            logic [HEIGHT_W-1:0] peak;
        } heights_t;

        int unsigned attack, decay, hold, accel;
        int unsigned bar_lvl[N_BANDS];
        int unsigned peak_lvl[N_BANDS];
        int unsigned speed[N_BANDS];
        int unsigned held[N_BANDS];
        bit          falling[N_BANDS];
        heights_t    pending_heights[$];
        int          mismatches;

        function new();
            attack = RST_ATTACK;
            decay  = RST_DECAY;
            hold   = RST_HOLD;
            accel  = RST_ACCEL;
            for (int b = 0; b < N_BANDS; b++) begin
                bar_lvl[b]  = 0;
                peak_lvl[b] = 0;
                speed[b]    = 0;
                held[b]     = 0;
                falling[b]  = 1'b0;
            end
            mismatches = 0;
        endfunction

        // Round level * visibility back to whole LED steps and saturate.
        function logic [HEIGHT_W-1:0] to_height(int unsigned lvl, int unsigned vis);
            int unsigned h;
            h = (lvl * vis + 32768) >> 16;
            return (h > 255) ? 8'd255 : h[HEIGHT_W-1:0];
        endfunction

        function void set_regs(int unsigned a, int unsigned d, int unsigned h,
                               int unsigned p);
            attack = a;
            decay  = d;
            hold   = h;
            accel  = p;
        endfunction

        // Advance one band by one tick and queue the heights it must show.
        function void take_update(logic [BAND_W-1:0] band, logic fresh,
                                  logic [LEVEL_W-1:0] level, logic [VIS_W-1:0] vis_in);
            heights_t        r;
            int unsigned     b, vis, lvl, tgt, c, pk, sp;
            longint unsigned mix;
            r.band = band;
            b      = band;
            if (b >= N_BANDS) begin
                // out-of-range band: echo it, show nothing, touch no state
                r.bar  = '0;
                r.peak = '0;
                pending_heights.push_back(r);
                return;
            end
            vis = (vis_in > VIS_ONE) ? VIS_ONE : vis_in;

            lvl = bar_lvl[b];
            tgt = fresh ? level : ((lvl * decay + 32768) >> 16);
            c   = (tgt > lvl) ? attack : decay;
            mix = longint'(tgt) * (65536 - longint'(c)) + longint'(lvl) * c + 32768;
            lvl = int'(mix >> 16);
            if (lvl > MAX16) lvl = MAX16;
            if (lvl < SNAP_Q88) lvl = 0;
            bar_lvl[b] = lvl;

            pk = peak_lvl[b];
            if (lvl >= pk) begin
                pk         = lvl;
                held[b]    = 0;
                falling[b] = 1'b0;
                speed[b]   = 0;
            end else begin
                if (!falling[b]) begin
                    if (held[b] < MAX16) held[b]++;
                    if (held[b] >= hold) begin
                        falling[b] = 1'b1;
                        speed[b]   = 0;
                    end
                end
                if (falling[b]) begin
                    sp = speed[b] + accel;
                    if (sp > MAX16) sp = MAX16;
                    speed[b] = sp;
                    if (sp >= pk || pk - sp <= lvl) begin
                        pk         = lvl;
                        falling[b] = 1'b0;
                        speed[b]   = 0;
                    end else begin
                        pk -= sp;
                    end
                end
            end
            peak_lvl[b] = pk;

            r.bar  = to_height(lvl, vis);
            r.peak = to_height(pk, vis);
            // a stray peak of one step over an empty bar is blanked
            if (r.bar == 0 && r.peak <= 1) r.peak = '0;
            pending_heights.push_back(r);
        endfunction

        function void check_heights(logic [BAND_W-1:0] band, logic [HEIGHT_W-1:0] bar,
                                    logic [HEIGHT_W-1:0] peak);
            heights_t want;
            if (pending_heights.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result band=%0d bar=%0d peak=%0d",
                             $realtime, band, bar, peak);
                return;
            end
            want = pending_heights.pop_front();
            if (band !== want.band || bar !== want.bar || peak !== want.peak) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp band=%0d bar=%0d peak=%0d, got band=%0d bar=%0d peak=%0d",
                             $realtime, want.band, want.bar, want.peak, band, bar, peak);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block I/O
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [BAND_W-1:0]     i_in_band = '0;
    logic                  i_has_new_level = 1'b0;
    logic [LEVEL_W-1:0]    i_new_level = '0;
    logic [VIS_W-1:0]      i_visibility = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [BAND_W-1:0]     o_out_band;
    logic [HEIGHT_W-1:0]   o_bar_height;
    logic [HEIGHT_W-1:0]   o_peak_height;

    meter_tracker tracker;
    int           idle_odds = 4;    // 1-in-N chance of an idle burst; 0 = none
    int           stall_left = 0;
    int           cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bar_peak_meter_ballistics #(
        .BANDS(N_BANDS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_band      (i_in_band),
        .i_has_new_level(i_has_new_level),
        .i_new_level    (i_new_level),
        .i_visibility   (i_visibility),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_band     (o_out_band),
        .o_bar_height   (o_bar_height),
        .o_peak_height  (o_peak_height)
    );

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Height channel: check every transfer, then pick ready for the next edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && i_ready)
                tracker.check_heights(o_out_band, o_bar_height, o_peak_height);
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_ready    <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                stall_left <= $urandom_range(0, 8);
                i_ready    <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Update channel driver. Called at a rising edge; returns at the edge where
    // the update transfers, leaving valid high so a back-to-back update can
    // follow without a bubble.
    // ------------------------------------------------------------------------
    task automatic send_update(logic [BAND_W-1:0] band, logic fresh,
                               logic [LEVEL_W-1:0] level, logic [VIS_W-1:0] vis);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_in_band       <= band;
        i_has_new_level <= fresh;
        i_new_level     <= level;
        i_visibility    <= vis;
        do @(posedge i_clk); while (!o_ready);
        tracker.take_update(band, fresh, level, vis);
    endtask

    // Hold until every predicted result has been transferred, then let the
    // pipeline settle.
    task automatic wait_drained();
        while (tracker.pending_heights.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive edges while the block is idle.
    task automatic apply_settings(logic [CFG_DATA_W-1:0] attack, logic [CFG_DATA_W-1:0] decay,
                                  logic [CFG_DATA_W-1:0] hold, logic [CFG_DATA_W-1:0] accel);
        i_valid <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_ATTACK;
        i_cfg_wdata <= attack;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_DECAY;
        i_cfg_wdata <= decay;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_HOLD;
        i_cfg_wdata <= hold;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_ACCEL;
        i_cfg_wdata <= accel;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_regs(attack, decay, hold, accel);
    endtask

    // ------------------------------------------------------------------------
    // Random phase: most updates hit a few focus bands so that peaks get held
    // and then fall; the rest land anywhere, including out-of-range bands.
    // Targets mix loud pulses, silence, near-snap levels and noise.
    // ------------------------------------------------------------------------
    task automatic run_random_phase(int count);
        logic [BAND_W-1:0]  focus[3];
        logic [BAND_W-1:0]  band;
        logic               fresh;
        logic [LEVEL_W-1:0] level;
        logic [VIS_W-1:0]   vis;
        int                 sel;
        for (int f = 0; f < 3; f++) focus[f] = BAND_W'($urandom_range(0, N_BANDS - 1));
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) < 7) band = focus[$urandom_range(0, 2)];
            else band = BAND_W'($urandom_range(0, 31));
            fresh = ($urandom_range(0, 99) < 55);
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1: level = LEVEL_W'($urandom_range(16'h4000, 16'hFFFF));
                2, 3: level = '0;
                4: level = LEVEL_W'($urandom_range(0, 40));
                default: level = LEVEL_W'($urandom);
            endcase
            sel = $urandom_range(0, 9);
            case (sel)
                6: vis = VIS_W'($urandom_range(0, 255));
                7, 8: vis = VIS_W'($urandom_range(257, 511));
                9: vis = VIS_W'($urandom_range(0, 511));
                default: vis = VIS_ONE;
            endcase
            send_update(band, fresh, level, vis);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        tracker = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset defaults: full-scale attack, decay, idle
        // decay with a stale level present, visibility clamp and zero,
        // out-of-range bands, snap to zero, stray peak over an empty bar.
        send_update(5'd0, 1'b1, 16'hFFFF, VIS_ONE);
        send_update(5'd0, 1'b1, 16'hFFFF, VIS_ONE);
        send_update(5'd0, 1'b1, 16'h0000, VIS_ONE);
        send_update(5'd0, 1'b0, 16'h1234, VIS_ONE);
        send_update(5'd23, 1'b1, 16'h8000, 9'd511);
        send_update(5'd23, 1'b1, 16'h8000, 9'd0);
        send_update(5'd24, 1'b1, 16'hFFFF, VIS_ONE);
        send_update(5'd31, 1'b1, 16'hAAAA, 9'h155);
        send_update(5'd1, 1'b1, 16'd20, VIS_ONE);
        send_update(5'd1, 1'b1, 16'd0, VIS_ONE);
        send_update(5'd2, 1'b1, 16'd400, VIS_ONE);
        send_update(5'd2, 1'b1, 16'd0, 9'd128);

        // Instant attack and decay, hold of one: peak starts to fall on the first lower update.
        apply_settings(16'd0, 16'd0, 16'd1, 16'd256);
        send_update(5'd3, 1'b1, 16'h6000, VIS_ONE);
        send_update(5'd3, 1'b1, 16'h1000, VIS_ONE);
        send_update(5'd3, 1'b1, 16'h1000, VIS_ONE);
        send_update(5'd5, 1'b1, 16'h5555, 9'd200);

        // Frozen bar, no hold, saturating fall speed: peak drops onto the bar.
        apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        send_update(5'd3, 1'b1, 16'h1000, VIS_ONE);
        send_update(5'd4, 1'b1, 16'hFFFF, VIS_ONE);
        send_update(5'd6, 1'b0, 16'h0000, VIS_ONE);

        // Random phases, each under its own register settings.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_settings(RST_ATTACK, RST_DECAY, RST_HOLD, RST_ACCEL);
                1: apply_settings(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
                2: apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
                3: apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
                default: apply_settings(CFG_DATA_W'($urandom),
                                        CFG_DATA_W'($urandom_range(40000, 65535)),
                                        CFG_DATA_W'($urandom_range(0, 8)),
                                        CFG_DATA_W'($urandom_range(1, 600)));
            endcase
            // no idling in the last phase; elsewhere vary the idle density
            if (p == PHASES - 1) idle_odds = 0;
            else if (p % 3 == 0) idle_odds = 0;
            else if (p % 3 == 1) idle_odds = 8;
            else idle_odds = 3;
            run_random_phase(PHASE_ITEMS);
        end

        i_valid <= 1'b0;
        wait_drained();
        if (tracker.mismatches == 0 && tracker.pending_heights.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
